// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SFP_ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define SFP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/sfp_pkg.sv -----
// Types and constants of the starfield point projector.
package sfp_pkg;

    localparam logic [12:0] SCREEN_MAX = 13'd4096;
    localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
    localparam int          PIX_W      = 12;
    localparam int          DIVD_W     = 31;
    localparam int          DIVS_W     = 18;

    // Configuration register indexes
    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_SPREAD        = 2'd2;
    localparam logic [1:0] CFG_SPEED         = 2'd3;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_REDUCE,
        ST_READ,
        ST_CHECK,
        ST_DRAW,
        ST_MUL,
        ST_DEPTH,
        ST_PMUL,
        ST_PCMP,
        ST_DIV,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic        seeded;
        logic [24:0] x;
        logic [24:0] y;
        logic [16:0] z;
    } star_rec_t;

    typedef struct packed {
        logic              start;
        logic [DIVD_W-1:0] dividend;
        logic [DIVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [PIX_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/sfp_star_mem.sv -----
// Star record memory: one write port, one registered read port.
module sfp_star_mem
    import sfp_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
)
(
    input  logic      clk,
    input  logic      we,
    input  logic [AW-1:0] waddr,
    input  star_rec_t wdata,
    input  logic      re,
    input  logic [AW-1:0] raddr,
    output star_rec_t rdata
);

    star_rec_t mem [DEPTH];
    star_rec_t rdata_reg;

    // Write the addressed entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/sfp_div.sv -----
// Radix-2 restoring divider producing a pixel-wide quotient.
module sfp_div
    import sfp_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int DW = DIVS_W + PIX_W - 1;

    logic [DIVD_W-1:0] rem_reg;
    logic [DW-1:0]     den_reg;
    logic [PIX_W-1:0]  quo_reg;
    logic [3:0]        cnt_reg;
    logic              run_reg;
    logic              done_reg;
    logic              fits;

    assign fits = {{(DIVD_W-DW){1'b0}}, den_reg} <= rem_reg;

    // Control: count quotient bits, pulse done after the last one
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 4'(PIX_W - 1);
            end
            else if (run_reg)
            begin
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 4'd1;
                end
            end
        end
    end

    // Datapath: one trial subtract per cycle
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= req.dividend;
            den_reg <= {req.divisor, {(PIX_W-1){1'b0}}};
            quo_reg <= '0;
        end
        else if (run_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - {{(DIVD_W-DW){1'b0}}, den_reg};
            end
            quo_reg <= {quo_reg[PIX_W-2:0], fits};
            den_reg <= den_reg >> 1;
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ----- rtl/starfield_point_projector.sv -----
// Top level of the starfield point projector.
// The block takes one request at a time and returns one result for it. A
// drawn star goes through these steps: reduce the index modulo NUM_STARS by
// a reciprocal multiply, read the record, update the depth, then per axis
// the multiply, range check and the shared divide (a 12-bit quotient formed
// bit by bit, then a done pulse), and last write back and present the
// result. Each respawn (unseeded slot, depth below zero, off-screen point)
// adds three generator draws. A star that fails the column range check is
// respawned and returned undrawn; the longest request has an unseeded slot,
// depth below zero and a row quotient of zero. The block then returns to
// idle before it takes the next request, and waits in its last step while
// the output register is full and out_stall is high. After reset a clearing
// pass sweeps every entry of the star memory before the first request is
// taken; configuration writes are taken at any time.
module starfield_point_projector
    import sfp_pkg::*;
#(
    parameter int NUM_STARS = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [9:0]  star_index,
    input  logic [15:0] frame_delta,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        drawn,
    output logic [11:0] pixel_x,
    output logic [11:0] pixel_y,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int AW = (NUM_STARS > 1) ? $clog2(NUM_STARS) : 1;
    // Reciprocal of NUM_STARS, exact for any 10-bit index
    localparam logic [27:0] RECIP = 28'((64'd1 << 27) / 64'(NUM_STARS) + 64'd1);

    function automatic logic [31:0] lfsr_step8(input logic [31:0] s);
        logic [31:0] v;
        v = s;
        for (int k = 0; k < 8; k++)
        begin
            if (v[0])
            begin
                v = (v >> 1) ^ LFSR_MASK;
            end
            else
            begin
                v = v >> 1;
            end
        end
        return v;
    endfunction

    state_t state_reg, state_next, ret_reg;

    logic [12:0] width_reg, height_reg;
    logic [15:0] spread_reg, speed_reg;

    logic [15:0] red_reg;
    logic [9:0]  quo_idx_reg;
    logic [3:0]  k_reg;
    logic [15:0] delta_reg;
    logic [AW-1:0] clr_reg;

    logic [24:0] x_reg, y_reg;
    logic [16:0] z_reg;
    logic [31:0] lfsr_reg;
    logic [15:0] r_reg;
    logic [2:0]  step_reg;
    logic [31:0] prod_reg;
    logic        axis_reg;
    logic signed [39:0] num_reg;
    logic [30:0] lim_reg;
    logic [11:0] px_reg, py_reg;
    logic        on_reg;

    logic        out_valid_reg, drawn_reg;
    logic [11:0] pixel_x_reg, pixel_y_reg;

    logic [31:0] lfsr_adv;
    logic [31:0] spread_prod;
    logic [25:0] coord_diff;
    logic [24:0] nz;
    logic [12:0] w_clamp, h_clamp, dim_sel;
    logic signed [25:0] sum_sel;
    logic signed [39:0] num_next;
    logic [30:0] lim_next;
    logic [37:0] recip_prod;
    logic [26:0] quo_mul;
    logic        proj_bad;
    logic        out_load;
    logic [AW-1:0] addr;

    logic      mem_we, mem_re;
    logic [AW-1:0] mem_waddr;
    star_rec_t mem_wdata, mem_rdata;
    div_req_t  div_req;
    div_rsp_t  div_rsp;

    sfp_star_mem #(.DEPTH(NUM_STARS), .AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (addr),
        .rdata (mem_rdata)
    );

    sfp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Shared datapath terms
    assign addr        = red_reg[AW-1:0];
    assign lfsr_adv    = lfsr_step8(lfsr_reg);
    assign spread_prod = {16'd0, r_reg} * {16'd0, spread_reg};
    assign coord_diff  = {1'b0, spread_prod[31:7]} - {2'b00, spread_reg, 8'd0};
    assign nz          = {8'd0, z_reg} - {1'b0, prod_reg[31:8]};
    assign w_clamp     = (width_reg > SCREEN_MAX) ? SCREEN_MAX : width_reg;
    assign h_clamp     = (height_reg > SCREEN_MAX) ? SCREEN_MAX : height_reg;
    assign dim_sel     = axis_reg ? h_clamp : w_clamp;
    assign sum_sel     = axis_reg ? ($signed({y_reg[24], y_reg}) + $signed({9'd0, z_reg}))
                                  : ($signed({x_reg[24], x_reg}) + $signed({9'd0, z_reg}));
    assign num_next    = 40'($signed({1'b0, dim_sel}) * sum_sel);
    assign lim_next    = 31'({18'd0, dim_sel} * {13'd0, z_reg, 1'b0});
    assign recip_prod  = {28'd0, red_reg[9:0]} * {10'd0, RECIP};
    assign quo_mul     = {17'd0, quo_idx_reg} * 27'(NUM_STARS);
    assign proj_bad    = (z_reg == '0) || num_reg[39] || (num_reg == '0)
                         || (num_reg[38:0] >= {8'd0, lim_reg});
    assign out_load    = (state_reg == ST_FIN) && (!out_valid_reg || !out_stall);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_reg == AW'(NUM_STARS - 1)) state_next = ST_IDLE;
            ST_IDLE:   if (in_valid) state_next = ST_REDUCE;
            ST_REDUCE: if (k_reg == '0) state_next = ST_READ;
            ST_READ:   state_next = ST_CHECK;
            ST_CHECK:  state_next = mem_rdata.seeded ? ST_MUL : ST_DRAW;
            ST_DRAW:   if (step_reg == 3'd6) state_next = ret_reg;
            ST_MUL:    state_next = ST_DEPTH;
            ST_DEPTH:  state_next = nz[24] ? ST_DRAW : ST_PMUL;
            ST_PMUL:   state_next = ST_PCMP;
            ST_PCMP:   state_next = proj_bad ? ST_DRAW : ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient == '0)
                    begin
                        state_next = ST_DRAW;
                    end
                    else
                    begin
                        state_next = axis_reg ? ST_FIN : ST_PMUL;
                    end
                end
            end
            ST_FIN:    if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // Memory and divider controls
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = addr;
        mem_wdata = {1'b1, x_reg, y_reg, z_reg};
        div_req   = '{start: 1'b0, dividend: num_reg[30:0], divisor: {z_reg, 1'b0}};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_READ:  mem_re = 1'b1;
            ST_PCMP:  div_req.start = !proj_bad;
            ST_FIN:   mem_we = out_load;
            default:  mem_we = 1'b0;
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            spread_reg <= 16'd256;
            speed_reg  <= 16'd256;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SCREEN_WIDTH:  width_reg  <= cfg_data[12:0];
                CFG_SCREEN_HEIGHT: height_reg <= cfg_data[12:0];
                CFG_SPREAD:        spread_reg <= cfg_data;
                CFG_SPEED:         speed_reg  <= cfg_data;
                default:           width_reg  <= width_reg;
            endcase
        end
    end

    // Control state: counters, generator, return target
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg  <= '0;
            k_reg    <= '0;
            step_reg <= '0;
            lfsr_reg <= 32'd1;
            axis_reg <= 1'b0;
            ret_reg  <= ST_FIN;
        end
        else
        begin
            unique case (state_reg)
                ST_CLEAR:  clr_reg <= clr_reg + AW'(1);
                ST_IDLE:   k_reg <= 4'd1;
                ST_REDUCE: k_reg <= k_reg - 4'd1;
                ST_CHECK:  ret_reg <= ST_MUL;
                ST_DEPTH:
                begin
                    ret_reg  <= ST_PMUL;
                    axis_reg <= 1'b0;
                end
                ST_PCMP:   ret_reg <= ST_FIN;
                ST_DIV:
                begin
                    ret_reg <= ST_FIN;
                    if (div_rsp.done && div_rsp.quotient != '0)
                    begin
                        axis_reg <= 1'b1;
                    end
                end
                ST_DRAW:
                begin
                    if (step_reg != 3'd6)
                    begin
                        lfsr_reg <= lfsr_adv;
                    end
                    step_reg <= (step_reg == 3'd6) ? 3'd0 : step_reg + 3'd1;
                    if (step_reg == 3'd6)
                    begin
                        axis_reg <= 1'b0;
                    end
                end
                default:   k_reg <= k_reg;
            endcase
        end
    end

    // Star datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                red_reg   <= {6'd0, star_index};
                delta_reg <= frame_delta;
                on_reg    <= 1'b0;
            end
            ST_REDUCE:
            begin
                // Quotient by reciprocal first, then take off the multiple
                if (k_reg != '0)
                begin
                    quo_idx_reg <= recip_prod[36:27];
                end
                else
                begin
                    red_reg <= red_reg - quo_mul[15:0];
                end
            end
            ST_CHECK:
            begin
                x_reg <= mem_rdata.x;
                y_reg <= mem_rdata.y;
                z_reg <= mem_rdata.z;
            end
            ST_DRAW:
            begin
                if (step_reg == 3'd1 || step_reg == 3'd3 || step_reg == 3'd5)
                begin
                    r_reg <= lfsr_adv[15:0];
                end
                if (step_reg == 3'd2)
                begin
                    x_reg <= coord_diff[24:0];
                end
                if (step_reg == 3'd4)
                begin
                    y_reg <= coord_diff[24:0];
                end
                if (step_reg == 3'd6)
                begin
                    z_reg <= {1'b0, r_reg} + 17'd1;
                end
            end
            ST_MUL:   prod_reg <= {16'd0, delta_reg} * {16'd0, speed_reg};
            ST_DEPTH:
            begin
                if (!nz[24])
                begin
                    z_reg <= nz[16:0];
                end
            end
            ST_PMUL:
            begin
                num_reg <= num_next;
                lim_reg <= lim_next;
            end
            ST_DIV:
            begin
                if (div_rsp.done && div_rsp.quotient != '0)
                begin
                    if (axis_reg)
                    begin
                        py_reg <= div_rsp.quotient;
                        on_reg <= 1'b1;
                    end
                    else
                    begin
                        px_reg <= div_rsp.quotient;
                    end
                end
            end
            default:  on_reg <= on_reg;
        endcase
    end

    // Output register: hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            drawn_reg   <= on_reg;
            pixel_x_reg <= on_reg ? px_reg : '0;
            pixel_y_reg <= on_reg ? py_reg : '0;
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign drawn     = drawn_reg;
    assign pixel_x   = pixel_x_reg;
    assign pixel_y   = pixel_y_reg;

endmodule

// ----- rtl/sfp_checker.sv -----
// Port-level checker for the starfield point projector, with its bind.
`include "assert_macros.svh"

module sfp_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic        drawn,
    input logic [11:0] pixel_x,
    input logic [11:0] pixel_y
);

    `SFP_ASSERT_CLK(a_out_hold, out_valid && out_stall |=> out_valid, "result dropped while stalled")
    `SFP_ASSERT_CLK(a_one_at_a_time, in_valid && !in_stall |=> in_stall, "second request taken while busy")
    `SFP_ASSERT_CLK(a_blank_zero, out_valid && !drawn |-> pixel_x == 12'd0 && pixel_y == 12'd0, "respawn result carries a pixel")
    `SFP_ASSERT_CLK(a_drawn_nonzero, out_valid && drawn |-> pixel_x != 12'd0 && pixel_y != 12'd0, "drawn pixel on row or column zero")
    `SFP_ASSERT_ALWAYS(a_reset_quiet, !rst_n |-> !out_valid, "result shown during reset")

endmodule

bind starfield_point_projector sfp_checker u_sfp_checker (.*);
